// ===== rtl/ptss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared types, constants and helpers of the priority thread slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

   // Size of the slot table.
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int NUM_PRIO  = 3;

   // Fixed widths of the words on the channels.
   localparam int REQ_TYPE_W    = 3;
   localparam int PRIO_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int SLOT_FIELD_W  = 3;
   localparam int COUNT_FIELD_W = 4;

   // Widths that hold both the internal value and the channel field.
   localparam int SLOT_EXT_W = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
   localparam int CNT_EXT_W  = (CNT_W > COUNT_FIELD_W) ? CNT_W : COUNT_FIELD_W;

   typedef logic [SLOT_W-1:0]     slot_idx_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [SLOT_EXT_W-1:0] slot_ext_type;
   typedef logic [CNT_EXT_W-1:0]  count_ext_type;

   // Request codes.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_CREATE = 3'd0,
      REQ_START  = 3'd1,
      REQ_YIELD  = 3'd2,
      REQ_EXIT   = 3'd3,
      REQ_SET    = 3'd4
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_SLOT = 2'd1,
      ST_REFUSED = 2'd2,
      ST_DONE    = 2'd3
   } rsp_status_type;

   // Priority levels; the unused code is read as low.
   typedef enum logic [PRIO_W-1:0] {
      PRIO_LOW  = 2'd0,
      PRIO_MED  = 2'd1,
      PRIO_HIGH = 2'd2
   } prio_type;

   // Per-slot state.
   typedef enum logic [1:0] {
      SLOT_FREE     = 2'd0,
      SLOT_RUNNABLE = 2'd1,
      SLOT_RUNNING  = 2'd2
   } slot_state_type;

   // Controller states.
   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_EXEC = 1'b1
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the accepted request word
      logic commit;    // update the slot table and load the result word
   } ptss_cmd_type;

   // Result word as held in the output register.
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [SLOT_FIELD_W-1:0]  slot;
      logic                     slot_valid;
      logic [PRIO_W-1:0]        old_prio;
      logic [PRIO_W-1:0]        current_prio;
      logic [COUNT_FIELD_W-1:0] active_count;
      logic [COUNT_FIELD_W-1:0] class_count;
   } rsp_word_type;

   // Maps the raw priority code onto a level; the fourth code counts as low.
   function automatic prio_type norm_prio(input logic [PRIO_W-1:0] raw);
      prio_type level;
      unique case (raw)
         PRIO_MED:  level = PRIO_MED;
         PRIO_HIGH: level = PRIO_HIGH;
         default:   level = PRIO_LOW;
      endcase
      return level;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ptss_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_req_if
// Request channel of the scheduler: valid/ready and the request word.
// ----------------------------------------------------------------------------
interface ptss_req_if;
   logic                            valid;
   logic                            ready;
   logic [ptss_pkg::REQ_TYPE_W-1:0] req_type;
   logic [ptss_pkg::PRIO_W-1:0]     prio;

   modport source (output valid, output req_type, output prio, input ready);
   modport sink   (input valid, input req_type, input prio, output ready);
endinterface
`default_nettype wire

// ===== rtl/ptss_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_rsp_if
// Result channel of the scheduler: valid/ready and the result word.
// ----------------------------------------------------------------------------
interface ptss_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ptss_pkg::STATUS_W-1:0]      status;
   logic [ptss_pkg::SLOT_FIELD_W-1:0]  slot;
   logic                               slot_valid;
   logic [ptss_pkg::PRIO_W-1:0]        old_prio;
   logic [ptss_pkg::PRIO_W-1:0]        current_prio;
   logic [ptss_pkg::COUNT_FIELD_W-1:0] active_count;
   logic [ptss_pkg::COUNT_FIELD_W-1:0] class_count;

   modport source (
      output valid, output status, output slot, output slot_valid,
      output old_prio, output current_prio, output active_count,
      output class_count, input ready
   );
   modport sink (
      input valid, input status, input slot, input slot_valid,
      input old_prio, input current_prio, input active_count,
      input class_count, output ready
   );
endinterface
`default_nettype wire

// ===== rtl/ptss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_ctrl
// Controller: takes one request word, holds it in the execute state until the
// output register is free and then hands the result word to it.
// ----------------------------------------------------------------------------
module ptss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ptss_pkg::ptss_cmd_type cmd
);

   ptss_pkg::ctrl_state_type state_ff;
   ptss_pkg::ctrl_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     out_free;

   // The output register can take a word when empty or emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptss_pkg::CTRL_IDLE: begin
            if (req_valid) begin
               state_in = ptss_pkg::CTRL_EXEC;
            end
         end
         ptss_pkg::CTRL_EXEC: begin
            if (out_free) begin
               state_in = ptss_pkg::CTRL_IDLE;
            end
         end
         default: state_in = ptss_pkg::CTRL_IDLE;
      endcase
   end

   // Outputs to the channels and commands to the datapath.
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ptss_pkg::CTRL_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ptss_pkg::CTRL_EXEC: begin
            cmd.commit = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result word valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptss_pkg::CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ptss_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_dpath
// Datapath: slot table, running thread, counters, the slot selectors and
// the result register.
// ----------------------------------------------------------------------------
module ptss_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  ptss_pkg::ptss_cmd_type          cmd,
   input  logic [ptss_pkg::REQ_TYPE_W-1:0] req_type,
   input  logic [ptss_pkg::PRIO_W-1:0]     req_prio,
   output ptss_pkg::rsp_word_type          rsp_word
);

   // Latched request word.
   logic [ptss_pkg::REQ_TYPE_W-1:0] req_type_ff;
   ptss_pkg::prio_type              req_prio_ff;

   // Scheduler state.
   ptss_pkg::slot_state_type slot_state_ff [ptss_pkg::NUM_SLOTS];
   ptss_pkg::slot_state_type slot_state_in [ptss_pkg::NUM_SLOTS];
   ptss_pkg::prio_type       slot_prio_ff  [ptss_pkg::NUM_SLOTS];
   ptss_pkg::prio_type       slot_prio_in  [ptss_pkg::NUM_SLOTS];
   ptss_pkg::slot_idx_type   run_slot_ff;
   ptss_pkg::slot_idx_type   run_slot_in;
   logic                     run_valid_ff;
   logic                     run_valid_in;
   logic                     started_ff;
   logic                     started_in;
   ptss_pkg::count_type      active_ff;
   ptss_pkg::count_type      active_in;
   ptss_pkg::count_type      class_cnt_ff [ptss_pkg::NUM_PRIO];
   ptss_pkg::count_type      class_cnt_in [ptss_pkg::NUM_PRIO];

   ptss_pkg::rsp_word_type   rsp_word_ff;
   ptss_pkg::rsp_word_type   rsp_word_in;

   // Selector results.
   logic                          free_found;
   ptss_pkg::slot_idx_type        free_idx;
   logic [ptss_pkg::NUM_SLOTS-1:0] ready_mask [ptss_pkg::NUM_PRIO];
   logic [ptss_pkg::NUM_SLOTS-1:0] pick_mask;
   logic                          pick_found;
   ptss_pkg::prio_type            pick_lvl;
   ptss_pkg::slot_idx_type        pick_idx;
   ptss_pkg::prio_type            cur_prio;

   // Step results before packing.
   ptss_pkg::rsp_status_type status_v;
   ptss_pkg::slot_idx_type   slot_v;
   logic                     slot_ok;
   ptss_pkg::prio_type       old_v;
   ptss_pkg::prio_type       new_prio_v;
   ptss_pkg::slot_ext_type   slot_ext;
   ptss_pkg::count_ext_type  active_ext;
   ptss_pkg::count_ext_type  class_ext;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ptss_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (slot_state_ff[i] == ptss_pkg::SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = ptss_pkg::slot_idx_type'(i);
         end
      end
   end

   // Runnable slots sorted into one mask per priority level.
   always_comb begin
      for (int l = 0; l < ptss_pkg::NUM_PRIO; l++) begin
         for (int i = 0; i < ptss_pkg::NUM_SLOTS; i++) begin
            ready_mask[l][i] = (slot_state_ff[i] == ptss_pkg::SLOT_RUNNABLE) &&
                               (slot_prio_ff[i] == ptss_pkg::prio_type'(l));
         end
      end
   end

   // Highest level that has a runnable slot, then its lowest index.
   always_comb begin
      pick_found = 1'b1;
      priority if (ready_mask[ptss_pkg::PRIO_HIGH] != '0) begin
         pick_lvl  = ptss_pkg::PRIO_HIGH;
         pick_mask = ready_mask[ptss_pkg::PRIO_HIGH];
      end else if (ready_mask[ptss_pkg::PRIO_MED] != '0) begin
         pick_lvl  = ptss_pkg::PRIO_MED;
         pick_mask = ready_mask[ptss_pkg::PRIO_MED];
      end else begin
         pick_lvl   = ptss_pkg::PRIO_LOW;
         pick_mask  = ready_mask[ptss_pkg::PRIO_LOW];
         pick_found = (ready_mask[ptss_pkg::PRIO_LOW] != '0);
      end
   end

   always_comb begin
      pick_idx = '0;
      for (int i = ptss_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (pick_mask[i]) begin
            pick_idx = ptss_pkg::slot_idx_type'(i);
         end
      end
   end

   assign cur_prio = slot_prio_ff[run_slot_ff];

   // Request execution: next state of the table and the result fields.
   always_comb begin
      slot_state_in = slot_state_ff;
      slot_prio_in  = slot_prio_ff;
      run_slot_in   = run_slot_ff;
      run_valid_in  = run_valid_ff;
      started_in    = started_ff;
      active_in     = active_ff;
      class_cnt_in  = class_cnt_ff;
      status_v      = ptss_pkg::ST_REFUSED;
      slot_v        = '0;
      slot_ok       = 1'b0;
      old_v         = ptss_pkg::PRIO_LOW;
      new_prio_v    = cur_prio;

      unique case (req_type_ff)
         ptss_pkg::REQ_CREATE: begin
            if (free_found) begin
               slot_state_in[free_idx]   = ptss_pkg::SLOT_RUNNABLE;
               slot_prio_in[free_idx]    = req_prio_ff;
               active_in                 = active_ff + 1'b1;
               class_cnt_in[req_prio_ff] = class_cnt_ff[req_prio_ff] + 1'b1;
               status_v                  = ptss_pkg::ST_OK;
               slot_v                    = free_idx;
               slot_ok                   = 1'b1;
            end else begin
               status_v = ptss_pkg::ST_NO_SLOT;
            end
         end
         ptss_pkg::REQ_START: begin
            if (!started_ff && active_ff != '0) begin
               started_in = 1'b1;
               status_v   = ptss_pkg::ST_OK;
               if (pick_found) begin
                  if (run_valid_ff) begin
                     slot_state_in[run_slot_ff] = ptss_pkg::SLOT_RUNNABLE;
                  end
                  slot_state_in[pick_idx] = ptss_pkg::SLOT_RUNNING;
                  run_slot_in             = pick_idx;
                  run_valid_in            = 1'b1;
                  new_prio_v              = pick_lvl;
               end
            end
         end
         ptss_pkg::REQ_YIELD: begin
            if (run_valid_ff && pick_found) begin
               slot_state_in[run_slot_ff] = ptss_pkg::SLOT_RUNNABLE;
               slot_state_in[pick_idx]    = ptss_pkg::SLOT_RUNNING;
               run_slot_in                = pick_idx;
               new_prio_v                 = pick_lvl;
               status_v                   = ptss_pkg::ST_OK;
            end
         end
         ptss_pkg::REQ_EXIT: begin
            if (run_valid_ff) begin
               slot_state_in[run_slot_ff] = ptss_pkg::SLOT_FREE;
               run_valid_in               = 1'b0;
               run_slot_in                = '0;
               active_in                  = active_ff - 1'b1;
               class_cnt_in[cur_prio]     = class_cnt_ff[cur_prio] - 1'b1;
               // The running slot is not runnable, so the pick still holds.
               if (active_in == '0) begin
                  status_v = ptss_pkg::ST_DONE;
               end else if (pick_found) begin
                  slot_state_in[pick_idx] = ptss_pkg::SLOT_RUNNING;
                  run_slot_in             = pick_idx;
                  run_valid_in            = 1'b1;
                  new_prio_v              = pick_lvl;
                  status_v                = ptss_pkg::ST_OK;
               end
            end
         end
         ptss_pkg::REQ_SET: begin
            if (run_valid_ff) begin
               old_v                     = cur_prio;
               slot_prio_in[run_slot_ff] = req_prio_ff;
               class_cnt_in[cur_prio]    = class_cnt_ff[cur_prio] - 1'b1;
               class_cnt_in[req_prio_ff] = class_cnt_in[req_prio_ff] + 1'b1;
               new_prio_v                = req_prio_ff;
               status_v                  = ptss_pkg::ST_OK;
            end
         end
         default: begin
            status_v = ptss_pkg::ST_REFUSED;
         end
      endcase

      // Every request but create reports the thread running afterwards.
      if (req_type_ff != ptss_pkg::REQ_CREATE && run_valid_in) begin
         slot_v  = run_slot_in;
         slot_ok = 1'b1;
      end
   end

   // Pack the result word, fitting slot and counts to the field widths.
   always_comb begin
      slot_ext   = ptss_pkg::slot_ext_type'(slot_v);
      active_ext = ptss_pkg::count_ext_type'(active_in);
      class_ext  = ptss_pkg::count_ext_type'(class_cnt_in[req_prio_ff]);

      rsp_word_in.status       = status_v;
      rsp_word_in.slot         = slot_ext[ptss_pkg::SLOT_FIELD_W-1:0];
      rsp_word_in.slot_valid   = slot_ok;
      rsp_word_in.old_prio     = old_v;
      rsp_word_in.current_prio = run_valid_in ? new_prio_v : ptss_pkg::PRIO_LOW;
      rsp_word_in.active_count = active_ext[ptss_pkg::COUNT_FIELD_W-1:0];
      rsp_word_in.class_count  = class_ext[ptss_pkg::COUNT_FIELD_W-1:0];
   end

   // Request word and result register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         req_prio_ff <= ptss_pkg::norm_prio(req_prio);
      end
      if (cmd.commit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // Scheduler state, updated once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ptss_pkg::NUM_SLOTS; i++) begin
            slot_state_ff[i] <= ptss_pkg::SLOT_FREE;
            slot_prio_ff[i]  <= ptss_pkg::PRIO_LOW;
         end
         for (int l = 0; l < ptss_pkg::NUM_PRIO; l++) begin
            class_cnt_ff[l] <= '0;
         end
         run_slot_ff  <= '0;
         run_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         active_ff    <= '0;
      end else if (cmd.commit) begin
         slot_state_ff <= slot_state_in;
         slot_prio_ff  <= slot_prio_in;
         class_cnt_ff  <= class_cnt_in;
         run_slot_ff   <= run_slot_in;
         run_valid_ff  <= run_valid_in;
         started_ff    <= started_in;
         active_ff     <= active_in;
      end
   end

   assign rsp_word = rsp_word_ff;

endmodule
`default_nettype wire

// ===== rtl/priority_thread_slot_scheduler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_thread_slot_scheduler_top
// Fixed-priority scheduler over a table of thread slots.
// ----------------------------------------------------------------------------
// Usage:
// - req_chan carries one request word (req_type, prio); it is taken when
//   valid and ready are both high at a rising clock edge.
// - rsp_chan returns exactly one result word per request, in order, through
//   an output register held until the receiver takes it.
// - A request is executed in the execute state after it is taken; its
//   result word is loaded once the output register is free.
// - One request is in work at a time: a new one is taken only once the
//   single execute step that reads and rewrites the slot table is done.
// - While the receiver stalls, one more request is taken and waits in the
//   execute step until the output register is freed.
// - Synchronous reset frees every slot, clears the counters, the running
//   thread and the start flag, and empties the output register. No clearing
//   pass is needed; requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module priority_thread_slot_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   ptss_req_if.sink    req_chan,
   ptss_rsp_if.source  rsp_chan
);

   ptss_pkg::ptss_cmd_type cmd;
   ptss_pkg::rsp_word_type rsp_word;

   // Sequencing of request, execute and result.
   ptss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   // Slot table and selection logic.
   ptss_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_type (req_chan.req_type),
      .req_prio (req_chan.prio),
      .rsp_word (rsp_word)
   );

   // Result word onto the channel.
   assign rsp_chan.status       = rsp_word.status;
   assign rsp_chan.slot         = rsp_word.slot;
   assign rsp_chan.slot_valid   = rsp_word.slot_valid;
   assign rsp_chan.old_prio     = rsp_word.old_prio;
   assign rsp_chan.current_prio = rsp_word.current_prio;
   assign rsp_chan.active_count = rsp_word.active_count;
   assign rsp_chan.class_count  = rsp_word.class_count;

endmodule
`default_nettype wire

// ===== rtl/ptss_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ptss_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [ptss_pkg::STATUS_W-1:0]      status,
   input logic [ptss_pkg::SLOT_FIELD_W-1:0]  slot,
   input logic                               slot_valid,
   input logic [ptss_pkg::PRIO_W-1:0]        current_prio,
   input logic [ptss_pkg::COUNT_FIELD_W-1:0] active_count
);

   // Reset leaves no result word pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // Only one request is in work: none is taken in the cycle after one.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in work");

   // A stalled result word keeps its status and slot.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(slot)))
      else $error("stalled result word changed");

   // When the last thread has exited nothing runs and nothing is left.
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ptss_pkg::ST_DONE) |->
      (!slot_valid && current_prio == '0 && active_count == '0))
      else $error("all-done result with a thread still present");

   // A slot field without meaning reads as zero.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !slot_valid) |-> (slot == '0))
      else $error("slot field set without slot_valid");

endmodule

bind priority_thread_slot_scheduler_top ptss_checker u_ptss_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .slot         (rsp_chan.slot),
   .slot_valid   (rsp_chan.slot_valid),
   .current_prio (rsp_chan.current_prio),
   .active_count (rsp_chan.active_count)
);
`default_nettype wire
